/* rtl/phd_pkg.sv */
// ----------------------------------------------------------------------------
// phd_pkg
// Shared types, constants and helpers of the proximity haptic drive.
// ----------------------------------------------------------------------------
package phd_pkg;

    localparam int NUM_SENSORS    = 8;
    localparam int AVG_DEPTH      = 2;
    localparam int RANGE_CAP_CM   = 80;
    localparam int FRONT_PULSE_MS = 50;
    localparam int PWM_LIMIT      = 1000;

    localparam int CMD_W     = 2;
    localparam int SENSOR_W  = 3;
    localparam int MM_W      = 13;
    localparam int TIME_W    = 32;
    localparam int CM_W      = 7;
    localparam int DUTY_W    = 7;
    localparam int CMP_W     = 10;
    localparam int REG_W     = 7;
    localparam int REG_IDX_W = 3;
    localparam int SUM_W     = $clog2(AVG_DEPTH * (2**CM_W - 1) + 1);

    localparam int CMP_FULL   = 2**CMP_W - 1;
    localparam int CMP_FLOOR  = CMP_FULL - PWM_LIMIT;
    localparam int DUTY_RESET = 100;

    // divide by ten through reciprocal, exact for 16-bit dividends
    localparam int DIV10_MUL   = 52429;
    localparam int DIV10_SHIFT = 19;

    localparam logic [NUM_SENSORS-1:0] LEFT_MASK  = 8'b1110_0000;
    localparam logic [NUM_SENSORS-1:0] RIGHT_MASK = 8'b0000_0111;

    typedef logic [CM_W-1:0]   cm_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [DUTY_W-1:0] duty_t;
    typedef logic [CMP_W-1:0]  cmp_t;
    typedef logic [TIME_W-1:0] time_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_READING  = 2'd0,
        CMD_EVALUATE = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_IDLE     = 2'd3
    } cmd_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FORWARD_DANGER = 3'd0,
        REG_DANGER         = 3'd1,
        REG_NEAR           = 3'd2,
        REG_FAR            = 3'd3,
        REG_DUTY_DANGER    = 3'd4,
        REG_DUTY_NEAR      = 3'd5,
        REG_DUTY_FAR       = 3'd6,
        REG_FRONT_DUTY     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [REG_W-1:0] forward_danger_cm;
        logic [REG_W-1:0] danger_cm;
        logic [REG_W-1:0] near_cm;
        logic [REG_W-1:0] far_cm;
        logic [REG_W-1:0] duty_danger;
        logic [REG_W-1:0] duty_near;
        logic [REG_W-1:0] duty_far;
        logic [REG_W-1:0] front_duty;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        forward_danger_cm: 7'd75,
        danger_cm:         7'd25,
        near_cm:           7'd55,
        far_cm:            7'd75,
        duty_danger:       7'd100,
        duty_near:         7'd80,
        duty_far:          7'd65,
        front_duty:        7'd100
    };

    typedef struct packed {
        duty_t left_duty;
        duty_t right_duty;
        logic  alarm;
    } drive_t;

    typedef struct packed {
        cmp_t left_compare;
        cmp_t right_compare;
        logic ref_high;
    } pwm_t;

    function automatic cm_t reading_cm(logic [MM_W-1:0] mm, logic fail);
        logic [MM_W+16-1:0]             prod;
        logic [MM_W+16-1-DIV10_SHIFT:0] quot;
        cm_t                            cm;
        prod = (MM_W+16)'(mm) * (MM_W+16)'(DIV10_MUL);
        quot = prod[MM_W+16-1:DIV10_SHIFT];
        if (fail || mm >= MM_W'(RANGE_CAP_CM * 10))
            cm = cm_t'(RANGE_CAP_CM);
        else
            cm = quot[CM_W-1:0];
        return cm;
    endfunction

    function automatic sum_t window_threshold(logic [REG_W-1:0] thr);
        return sum_t'(thr) * sum_t'(AVG_DEPTH);
    endfunction

endpackage

/* rtl/phd_if.sv */
// ----------------------------------------------------------------------------
// phd_if
// Channel interfaces: item request, result and register write.
// ----------------------------------------------------------------------------
interface phd_in_if;
    import phd_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [SENSOR_W-1:0] sensor_index;
    logic [MM_W-1:0]     range_mm;
    logic                phase_fail;
    logic [TIME_W-1:0]   time_ms;

    modport source (output valid, cmd, sensor_index, range_mm, phase_fail, time_ms,
                    input ready);
    modport sink   (input valid, cmd, sensor_index, range_mm, phase_fail, time_ms,
                    output ready);
endinterface

interface phd_out_if;
    import phd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic [CMP_W-1:0]  left_compare;
    logic [CMP_W-1:0]  right_compare;
    logic              ref_high;
    logic              front_alarm;

    modport source (output valid, left_duty, right_duty, left_compare, right_compare,
                    ref_high, front_alarm, input ready);
    modport sink   (input valid, left_duty, right_duty, left_compare, right_compare,
                    ref_high, front_alarm, output ready);
endinterface

interface phd_cfg_if;
    import phd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] addr;
    logic [REG_W-1:0]     data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

/* rtl/proximity_haptic_drive.sv */
// ----------------------------------------------------------------------------
// proximity_haptic_drive
// Haptic motor drive from eight range sensors.
//
// req carries one item per transaction: a sensor reading, an evaluate at a
// time in ms, a pwm tick or an idle command. Each item yields exactly one
// transaction on rsp holding the motor duties, compare values, reference
// level and front alarm as they stand after the item. cfg writes one of the
// eight thresholds and duties per transaction; it is always ready and is to
// be used only while idle, which the block itself does not enforce. An
// accepted item is held in the input register and then processed into the
// result register, which drives the transaction on rsp. One item per cycle
// is sustained while rsp does not stall, set by the single pass of compare
// and scaling logic between the two registers.
// When rsp stalls, the result register holds and req drops ready only once
// the input register is full too; no transaction is lost or repeated.
// Reset restores register defaults, fills every sensor window with 80 cm,
// sets both duties to 100 and clears compare values, polarity and pulsing.
// ----------------------------------------------------------------------------
module proximity_haptic_drive (
    input  logic      clk,
    input  logic      rst_n,
    phd_in_if.sink    req,
    phd_out_if.source rsp,
    phd_cfg_if.sink   cfg
);
    import phd_pkg::*;

    cfg_t cfg_reg;

    logic                in_valid_reg;
    cmd_t                cmd_reg;
    logic [SENSOR_W-1:0] sensor_reg;
    logic [MM_W-1:0]     mm_reg;
    logic                fail_reg;
    time_t               time_reg;

    logic   out_valid_reg;
    drive_t drive_res_reg;
    pwm_t   pwm_res_reg;

    logic   drain_ok, proc;
    sum_t [NUM_SENSORS-1:0] sums;
    drive_t drive_next;
    pwm_t   pwm_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg.valid)
        begin
            case (reg_idx_t'(cfg.addr))
                REG_FORWARD_DANGER: cfg_reg.forward_danger_cm <= cfg.data;
                REG_DANGER:         cfg_reg.danger_cm         <= cfg.data;
                REG_NEAR:           cfg_reg.near_cm           <= cfg.data;
                REG_FAR:            cfg_reg.far_cm            <= cfg.data;
                REG_DUTY_DANGER:    cfg_reg.duty_danger       <= cfg.data;
                REG_DUTY_NEAR:      cfg_reg.duty_near         <= cfg.data;
                REG_DUTY_FAR:       cfg_reg.duty_far          <= cfg.data;
                REG_FRONT_DUTY:     cfg_reg.front_duty        <= cfg.data;
                default:            cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    assign drain_ok  = !out_valid_reg || rsp.ready;
    assign proc      = in_valid_reg && drain_ok;
    assign req.ready = !in_valid_reg || drain_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            cmd_reg    <= cmd_t'(req.cmd);
            sensor_reg <= req.sensor_index;
            mm_reg     <= req.range_mm;
            fail_reg   <= req.phase_fail;
            time_reg   <= req.time_ms;
        end
    end

    phd_sensor_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (proc && cmd_reg == CMD_READING),
        .wr_sensor (sensor_reg),
        .wr_cm     (reading_cm(mm_reg, fail_reg)),
        .sums      (sums)
    );

    phd_drive_eval u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .eval_en    (proc && cmd_reg == CMD_EVALUATE),
        .now        (time_reg),
        .cfg        (cfg_reg),
        .sums       (sums),
        .drive_next (drive_next)
    );

    phd_pwm u_pwm (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick_en  (proc && cmd_reg == CMD_TICK),
        .drive    (drive_next),
        .pwm_next (pwm_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (drain_ok)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            drive_res_reg <= drive_next;
            pwm_res_reg   <= pwm_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.left_duty     = drive_res_reg.left_duty;
    assign rsp.right_duty    = drive_res_reg.right_duty;
    assign rsp.left_compare  = pwm_res_reg.left_compare;
    assign rsp.right_compare = pwm_res_reg.right_compare;
    assign rsp.ref_high      = pwm_res_reg.ref_high;
    assign rsp.front_alarm   = drive_res_reg.alarm;

    a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !drain_ok |-> !req.ready)
        else $error("input register overwritten while result stalled");

    a_one_motor_or_equal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.left_duty == '0 || rsp.right_duty == '0
                      || rsp.left_duty == rsp.right_duty)
        else $error("both motors driven at different duties");

    a_neg_floor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.ref_high |-> rsp.left_compare >= cmp_t'(CMP_FLOOR)
                                      && rsp.right_compare >= cmp_t'(CMP_FLOOR))
        else $error("negative polarity compare below floor");

    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ref_high |-> rsp.left_compare <= cmp_t'(PWM_LIMIT)
                                       && rsp.right_compare <= cmp_t'(PWM_LIMIT))
        else $error("positive polarity compare above limit");

endmodule

/* rtl/phd_sensor_window.sv */
// ----------------------------------------------------------------------------
// phd_sensor_window
// Per-sensor window of recent readings and the window sums.
// ----------------------------------------------------------------------------
module phd_sensor_window (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [phd_pkg::SENSOR_W-1:0]           wr_sensor,
    input  phd_pkg::cm_t                           wr_cm,
    output phd_pkg::sum_t [phd_pkg::NUM_SENSORS-1:0] sums
);
    import phd_pkg::*;

    cm_t win_reg [NUM_SENSORS][AVG_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SENSORS; s++)
            begin
                for (int k = 0; k < AVG_DEPTH; k++)
                begin
                    win_reg[s][k] <= cm_t'(RANGE_CAP_CM);
                end
            end
        end
        else if (wr_en)
        begin
            win_reg[wr_sensor][0] <= wr_cm;
            for (int k = 1; k < AVG_DEPTH; k++)
            begin
                win_reg[wr_sensor][k] <= win_reg[wr_sensor][k-1];
            end
        end
    end

    always_comb
    begin
        for (int s = 0; s < NUM_SENSORS; s++)
        begin
            sums[s] = '0;
            for (int k = 0; k < AVG_DEPTH; k++)
            begin
                sums[s] = sums[s] + sum_t'(win_reg[s][k]);
            end
        end
    end

endmodule

/* rtl/phd_drive_eval.sv */
// ----------------------------------------------------------------------------
// phd_drive_eval
// Grades front and side proximity into motor duties, with frontal pulsing.
// ----------------------------------------------------------------------------
module phd_drive_eval (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     eval_en,
    input  phd_pkg::time_t                           now,
    input  phd_pkg::cfg_t                            cfg,
    input  phd_pkg::sum_t [phd_pkg::NUM_SENSORS-1:0] sums,
    output phd_pkg::drive_t                          drive_next
);
    import phd_pkg::*;

    duty_t left_duty_reg, right_duty_reg;
    logic  side_left_reg, muted_reg, alarm_reg;
    time_t toggle_ms_reg;

    duty_t left_duty_next, right_duty_next;
    logic  side_left_next, muted_next, alarm_next;
    time_t toggle_ms_next;

    logic [NUM_SENSORS-1:0] near_fd, near_dg, near_nr, near_fr;
    logic  alarm, mute, toggle;
    duty_t front, left_lvl, right_lvl, left_raw, right_raw;
    time_t elapsed;

    always_comb
    begin
        for (int s = 0; s < NUM_SENSORS; s++)
        begin
            near_fd[s] = sums[s] < window_threshold(cfg.forward_danger_cm);
            near_dg[s] = sums[s] < window_threshold(cfg.danger_cm);
            near_nr[s] = sums[s] < window_threshold(cfg.near_cm);
            near_fr[s] = sums[s] < window_threshold(cfg.far_cm);
        end
    end

    always_comb
    begin
        if ((near_dg & LEFT_MASK) != '0)
            left_raw = cfg.duty_danger;
        else if ((near_nr & LEFT_MASK) != '0)
            left_raw = cfg.duty_near;
        else if ((near_fr & LEFT_MASK) != '0)
            left_raw = cfg.duty_far;
        else
            left_raw = '0;

        if ((near_dg & RIGHT_MASK) != '0)
            right_raw = cfg.duty_danger;
        else if ((near_nr & RIGHT_MASK) != '0)
            right_raw = cfg.duty_near;
        else if ((near_fr & RIGHT_MASK) != '0)
            right_raw = cfg.duty_far;
        else
            right_raw = '0;
    end

    assign alarm   = (near_fd[2] && near_fd[5]) || near_fd[3] || near_fd[4];
    assign mute    = alarm && muted_reg;
    assign elapsed = now - toggle_ms_reg;
    assign toggle  = alarm && (elapsed > time_t'(FRONT_PULSE_MS));

    assign front     = (alarm && !mute) ? cfg.front_duty : '0;
    assign left_lvl  = mute ? '0 : left_raw;
    assign right_lvl = mute ? '0 : right_raw;

    always_comb
    begin
        left_duty_next  = left_duty_reg;
        right_duty_next = right_duty_reg;
        side_left_next  = side_left_reg;
        muted_next      = muted_reg;
        toggle_ms_next  = toggle_ms_reg;
        alarm_next      = alarm_reg;
        if (eval_en)
        begin
            alarm_next = alarm;
            if (toggle)
            begin
                muted_next     = !muted_reg;
                toggle_ms_next = now;
            end
            if (front != '0)
            begin
                left_duty_next  = front;
                right_duty_next = front;
            end
            else if (left_lvl > right_lvl)
            begin
                left_duty_next  = left_lvl;
                right_duty_next = '0;
                side_left_next  = 1'b1;
            end
            else if (right_lvl > left_lvl)
            begin
                left_duty_next  = '0;
                right_duty_next = right_lvl;
                side_left_next  = 1'b0;
            end
            else if (left_lvl != '0 && side_left_reg)
            begin
                left_duty_next  = left_lvl;
                right_duty_next = '0;
            end
            else
            begin
                left_duty_next  = '0;
                right_duty_next = right_lvl;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_duty_reg  <= duty_t'(DUTY_RESET);
            right_duty_reg <= duty_t'(DUTY_RESET);
            side_left_reg  <= 1'b0;
            muted_reg      <= 1'b0;
            toggle_ms_reg  <= '0;
            alarm_reg      <= 1'b0;
        end
        else
        begin
            left_duty_reg  <= left_duty_next;
            right_duty_reg <= right_duty_next;
            side_left_reg  <= side_left_next;
            muted_reg      <= muted_next;
            toggle_ms_reg  <= toggle_ms_next;
            alarm_reg      <= alarm_next;
        end
    end

    assign drive_next.left_duty  = left_duty_next;
    assign drive_next.right_duty = right_duty_next;
    assign drive_next.alarm      = alarm_next;

endmodule

/* rtl/phd_pwm.sv */
// ----------------------------------------------------------------------------
// phd_pwm
// Polarity flip and clipped 10-bit compare values on each pwm tick.
// ----------------------------------------------------------------------------
module phd_pwm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tick_en,
    input  phd_pkg::drive_t drive,
    output phd_pkg::pwm_t   pwm_next
);
    import phd_pkg::*;

    // duty * 1023 / 100 through a reciprocal of 100
    localparam int SCALE_SHIFT = 24;
    localparam int SCALE_RECIP = (2**SCALE_SHIFT + 99) / 100;
    localparam int SCALE_MUL   = CMP_FULL * SCALE_RECIP;
    localparam int PROD_W      = DUTY_W + $clog2(SCALE_MUL + 1);
    localparam int SCL_W       = CMP_W + 1;

    function automatic cmp_t compare_of(duty_t duty, logic neg);
        logic [PROD_W-1:0] prod;
        logic [SCL_W-1:0]  scaled;
        logic [SCL_W-1:0]  inv;
        cmp_t              res;
        prod   = PROD_W'(duty) * PROD_W'(SCALE_MUL);
        scaled = prod[SCALE_SHIFT +: SCL_W];
        if (neg)
        begin
            inv = (scaled > SCL_W'(CMP_FULL)) ? '0 : SCL_W'(CMP_FULL) - scaled;
            if (inv < SCL_W'(CMP_FLOOR))
                inv = SCL_W'(CMP_FLOOR);
            res = inv[CMP_W-1:0];
        end
        else
        begin
            res = (scaled > SCL_W'(PWM_LIMIT)) ? cmp_t'(PWM_LIMIT) : scaled[CMP_W-1:0];
        end
        return res;
    endfunction

    logic polarity_reg, polarity_next;
    cmp_t left_cmp_reg, right_cmp_reg;
    logic ref_reg;
    logic active, neg;

    assign active        = (drive.left_duty != '0) || (drive.right_duty != '0);
    assign polarity_next = tick_en ? !polarity_reg : polarity_reg;
    assign neg           = polarity_next && active;

    always_comb
    begin
        pwm_next.left_compare  = left_cmp_reg;
        pwm_next.right_compare = right_cmp_reg;
        pwm_next.ref_high      = ref_reg;
        if (tick_en)
        begin
            pwm_next.left_compare  = compare_of(drive.left_duty, neg);
            pwm_next.right_compare = compare_of(drive.right_duty, neg);
            pwm_next.ref_high      = neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polarity_reg  <= 1'b0;
            left_cmp_reg  <= '0;
            right_cmp_reg <= '0;
            ref_reg       <= 1'b0;
        end
        else
        begin
            polarity_reg  <= polarity_next;
            left_cmp_reg  <= pwm_next.left_compare;
            right_cmp_reg <= pwm_next.right_compare;
            ref_reg       <= pwm_next.ref_high;
        end
    end

endmodule

/* tb/sv/phd_drive_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phd_drive_checker
// Watches the item, result and register channels of the haptic drive. It
// keeps its own copy of the sensor windows, drive state and registers,
// works out the status each accepted item should produce, and compares
// every result transaction against the oldest outstanding status.
// ----------------------------------------------------------------------------
module phd_drive_checker (
    input  logic clk,
    input  logic rst_n,
    phd_in_if    req,
    phd_out_if   rsp,
    phd_cfg_if   cfg,
    output int   mismatches,
    output int   pending_results,
    output int   alarm_evals
);
    import phd_pkg::*;

    typedef struct packed {
        duty_t left_duty;
        duty_t right_duty;
        cmp_t  left_compare;
        cmp_t  right_compare;
        logic  ref_high;
        logic  front_alarm;
    } drive_status_t;

    logic [REG_W-1:0] reg_file [8];
    cm_t              latest_cm [NUM_SENSORS];
    cm_t              prior_cm [NUM_SENSORS];
    duty_t            motor_duty [2];
    cmp_t             motor_cmp [2];
    logic             ref_lvl;
    logic             neg_phase;
    logic             prefer_left;
    logic             muted;
    time_t            toggle_at;
    logic             alarm_on;
    drive_status_t    status_q [$];

    function automatic bit is_near(int s, logic [REG_W-1:0] thr);
        return (int'(latest_cm[s]) + int'(prior_cm[s])) < AVG_DEPTH * int'(thr);
    endfunction

    function automatic int side_grade(int a, int b, int c);
        if (is_near(a, reg_file[REG_DANGER]) || is_near(b, reg_file[REG_DANGER]) ||
            is_near(c, reg_file[REG_DANGER]))
            return int'(reg_file[REG_DUTY_DANGER]);
        if (is_near(a, reg_file[REG_NEAR]) || is_near(b, reg_file[REG_NEAR]) ||
            is_near(c, reg_file[REG_NEAR]))
            return int'(reg_file[REG_DUTY_NEAR]);
        if (is_near(a, reg_file[REG_FAR]) || is_near(b, reg_file[REG_FAR]) ||
            is_near(c, reg_file[REG_FAR]))
            return int'(reg_file[REG_DUTY_FAR]);
        return 0;
    endfunction

    function automatic void store_reading(int s, logic [MM_W-1:0] mm, logic fail);
        int cm;
        if (fail || int'(mm) >= RANGE_CAP_CM * 10)
            cm = RANGE_CAP_CM;
        else
            cm = int'(mm) / 10;
        prior_cm[s]  = latest_cm[s];
        latest_cm[s] = cm_t'(cm);
    endfunction

    function automatic void grade_drive(time_t now);
        logic [REG_W-1:0] fwd;
        bit               alarm;
        int               front;
        int               left;
        int               right;
        time_t            since;
        fwd   = reg_file[REG_FORWARD_DANGER];
        alarm = (is_near(2, fwd) && is_near(5, fwd)) || is_near(3, fwd) || is_near(4, fwd);
        front = alarm ? int'(reg_file[REG_FRONT_DUTY]) : 0;
        left  = side_grade(5, 6, 7);
        right = side_grade(0, 1, 2);
        alarm_on = alarm;
        if (alarm) begin
            alarm_evals++;
            if (muted) begin
                left  = 0;
                right = 0;
                front = 0;
            end
            since = now - toggle_at;
            if (since > time_t'(FRONT_PULSE_MS)) begin
                muted     = ~muted;
                toggle_at = now;
            end
        end
        if (front != 0) begin
            motor_duty[0] = duty_t'(front);
            motor_duty[1] = duty_t'(front);
        end else if (left > right) begin
            motor_duty[0] = duty_t'(left);
            motor_duty[1] = '0;
            prefer_left   = 1'b1;
        end else if (right > left) begin
            motor_duty[0] = '0;
            motor_duty[1] = duty_t'(right);
            prefer_left   = 1'b0;
        end else if (left > 0 && prefer_left) begin
            motor_duty[0] = duty_t'(left);
            motor_duty[1] = '0;
        end else begin
            motor_duty[0] = '0;
            motor_duty[1] = duty_t'(right);
        end
    endfunction

    function automatic void pwm_step();
        bit active;
        int scaled;
        int v;
        active    = !(motor_duty[0] == 0 && motor_duty[1] == 0);
        neg_phase = ~neg_phase;
        for (int i = 0; i < 2; i++) begin
            scaled = int'(motor_duty[i]) * 1023 / 100;
            if (neg_phase && active) begin
                v = (scaled > CMP_FULL) ? 0 : CMP_FULL - scaled;
                if (v < CMP_FLOOR)
                    v = CMP_FLOOR;
            end else begin
                v = (scaled > PWM_LIMIT) ? PWM_LIMIT : scaled;
            end
            motor_cmp[i] = cmp_t'(v);
        end
        ref_lvl = neg_phase && active;
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        drive_status_t exp_status;
        if (!rst_n) begin
            for (int i = 0; i < 8; i++)
                reg_file[i] = CFG_RESET[(7 - i) * REG_W +: REG_W];
            for (int s = 0; s < NUM_SENSORS; s++) begin
                latest_cm[s] = cm_t'(RANGE_CAP_CM);
                prior_cm[s]  = cm_t'(RANGE_CAP_CM);
            end
            motor_duty[0]   = duty_t'(DUTY_RESET);
            motor_duty[1]   = duty_t'(DUTY_RESET);
            motor_cmp[0]    = '0;
            motor_cmp[1]    = '0;
            ref_lvl         = 1'b0;
            neg_phase       = 1'b0;
            prefer_left     = 1'b0;
            muted           = 1'b0;
            toggle_at       = '0;
            alarm_on        = 1'b0;
            status_q.delete();
            mismatches      = 0;
            pending_results = 0;
            alarm_evals     = 0;
        end else begin
            if (cfg.valid && cfg.ready)
                reg_file[cfg.addr] = cfg.data;

            if (rsp.valid && rsp.ready) begin
                if (status_q.size() == 0) begin
                    check_field("unexpected result transaction", 0, 1);
                end else begin
                    exp_status = status_q.pop_front();
                    check_field("left_duty", int'(exp_status.left_duty),
                                int'(rsp.left_duty));
                    check_field("right_duty", int'(exp_status.right_duty),
                                int'(rsp.right_duty));
                    check_field("left_compare", int'(exp_status.left_compare),
                                int'(rsp.left_compare));
                    check_field("right_compare", int'(exp_status.right_compare),
                                int'(rsp.right_compare));
                    check_field("ref_high", int'(exp_status.ref_high),
                                int'(rsp.ref_high));
                    check_field("front_alarm", int'(exp_status.front_alarm),
                                int'(rsp.front_alarm));
                end
            end

            if (req.valid && req.ready) begin
                case (cmd_t'(req.cmd))
                    CMD_READING:  store_reading(int'(req.sensor_index), req.range_mm,
                                                req.phase_fail);
                    CMD_EVALUATE: grade_drive(req.time_ms);
                    CMD_TICK:     pwm_step();
                    default:      ;
                endcase
                exp_status.left_duty     = motor_duty[0];
                exp_status.right_duty    = motor_duty[1];
                exp_status.left_compare  = motor_cmp[0];
                exp_status.right_compare = motor_cmp[1];
                exp_status.ref_high      = ref_lvl;
                exp_status.front_alarm   = alarm_on;
                status_q = {status_q, exp_status};
            end
            pending_results = status_q.size();
        end
    end

endmodule

/* tb/sv/proximity_haptic_drive_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_haptic_drive_test
// Stimulus and verdict for the haptic drive. A directed run covers reading
// clamps, phase failures, front pulsing across the timer wrap, the side tie
// rule and both pwm polarities; random runs follow under several register
// settings, with random gaps on both sides and one long result stall.
// ----------------------------------------------------------------------------
module proximity_haptic_drive_test;
    import phd_pkg::*;

    localparam int CYCLE_LIMIT      = 500000;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int HOLD_OFF_CYCLES  = 300;

    logic  clk;
    logic  rst_n;
    int    fail_count;
    int    outstanding;
    int    alarm_hits;
    int    cycle_count;
    int    settings_used;
    int    cmd_count [4];
    bit    quiet_run;
    bit    hold_off_req;
    time_t clock_ms;

    phd_in_if  item_ch ();
    phd_out_if status_ch ();
    phd_cfg_if reg_ch ();

    proximity_haptic_drive dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (item_ch),
        .rsp   (status_ch),
        .cfg   (reg_ch)
    );

    phd_drive_checker drive_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (item_ch),
        .rsp             (status_ch),
        .cfg             (reg_ch),
        .mismatches      (fail_count),
        .pending_results (outstanding),
        .alarm_evals     (alarm_hits)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(input cmd_t op, input logic [SENSOR_W-1:0] sensor,
                             input logic [MM_W-1:0] mm, input logic fail,
                             input time_t stamp);
        int gap;
        gap = quiet_run ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.cmd          <= op;
        item_ch.sensor_index <= sensor;
        item_ch.range_mm     <= mm;
        item_ch.phase_fail   <= fail;
        item_ch.time_ms      <= stamp;
        item_ch.valid        <= 1'b1;
        do @(posedge clk); while (!item_ch.ready);
        @(negedge clk);
        cmd_count[op]++;
    endtask

    task automatic post_reading(input int sensor, input int mm, input bit fail);
        send_item(CMD_READING, SENSOR_W'(sensor), MM_W'(mm), fail, $urandom);
    endtask

    task automatic post_eval(input time_t stamp);
        send_item(CMD_EVALUATE, SENSOR_W'($urandom), MM_W'($urandom), 1'($urandom),
                  stamp);
    endtask

    task automatic post_tick();
        send_item(CMD_TICK, SENSOR_W'($urandom), MM_W'($urandom), 1'($urandom),
                  $urandom);
    endtask

    task automatic program_regs(input cfg_t setting);
        for (int i = 0; i < 8; i++)
        begin
            reg_ch.addr  <= reg_idx_t'(i);
            reg_ch.data  <= setting[(7 - i) * REG_W +: REG_W];
            reg_ch.valid <= 1'b1;
            do @(posedge clk); while (!reg_ch.ready);
            @(negedge clk);
        end
        reg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [REG_W-1:0] pick_reg(input int upper);
        if ($urandom_range(0, 4) == 0)
            return REG_W'($urandom_range(0, 127));
        return REG_W'($urandom_range(0, upper));
    endfunction

    function automatic cfg_t random_setting();
        cfg_t c;
        c.forward_danger_cm = pick_reg(80);
        c.danger_cm         = pick_reg(40);
        c.near_cm           = c.danger_cm + REG_W'($urandom_range(0, 30));
        c.far_cm            = c.near_cm + REG_W'($urandom_range(0, 20));
        c.duty_danger       = pick_reg(100);
        c.duty_near         = pick_reg(100);
        c.duty_far          = pick_reg(100);
        c.front_duty        = pick_reg(100);
        return c;
    endfunction

    task automatic run_random(input int count);
        int pick;
        int r;
        int mm;
        for (int k = 0; k < count; k++)
        begin
            if (k % 60 == 0 && k != 0)
                quiet_run = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                r = $urandom_range(0, 9);
                if (r < 4)
                    mm = $urandom_range(0, 850);
                else if (r < 7)
                    mm = $urandom_range(700, 1200);
                else if (r < 9)
                    mm = $urandom_range(0, 300);
                else
                    mm = $urandom_range(0, 8191);
                post_reading($urandom_range(0, 7), mm, $urandom_range(0, 11) == 0);
            end
            else if (pick < 72)
            begin
                if ($urandom_range(0, 29) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(0, 80);
                post_eval(clock_ms);
            end
            else if (pick < 96)
                post_tick();
            else
                send_item(CMD_IDLE, SENSOR_W'($urandom), MM_W'($urandom),
                          1'($urandom), $urandom);
        end
    endtask

    initial
    begin
        status_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            int gap;
            if (hold_off_req)
            begin
                status_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            gap = quiet_run ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                status_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            status_ch.ready <= 1'b1;
            do @(posedge clk); while (!status_ch.valid);
            @(negedge clk);
        end
    end

    initial
    begin
        cfg_t settings [7];
        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.cmd          = CMD_IDLE;
        item_ch.sensor_index = '0;
        item_ch.range_mm     = '0;
        item_ch.phase_fail   = 1'b0;
        item_ch.time_ms      = '0;
        reg_ch.valid         = 1'b0;
        reg_ch.addr          = '0;
        reg_ch.data          = '0;
        quiet_run            = 1'b0;
        hold_off_req         = 1'b0;
        clock_ms             = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed run under reset register values
        post_tick();
        post_tick();
        send_item(CMD_IDLE, 3'd5, 13'h1FFF, 1'b1, 32'hFFFF_FFFF);
        post_reading(0, 0, 1'b0);
        post_reading(1, 799, 1'b0);
        post_reading(2, 800, 1'b0);
        post_reading(7, 8191, 1'b0);
        post_reading(6, 5, 1'b1);
        post_eval(32'd0);
        post_tick();
        post_reading(3, 100, 1'b0);
        post_reading(3, 100, 1'b0);
        post_eval(32'd10);
        post_eval(32'd61);
        post_eval(32'd70);
        post_tick();
        post_eval(32'hFFFF_FFF0);
        post_eval(32'h0000_0020);
        post_eval(32'h0000_0023);
        post_reading(3, 8191, 1'b0);
        post_reading(3, 8191, 1'b0);
        post_reading(6, 0, 1'b0);
        post_eval(32'd200);
        post_reading(6, 0, 1'b0);
        post_eval(32'd210);
        post_reading(0, 0, 1'b0);
        post_eval(32'd220);
        post_tick();

        // long result stall while items arrive back to back
        quiet_run    = 1'b1;
        hold_off_req = 1'b1;
        clock_ms     = 32'd300;
        run_random(RANDOM_PER_PHASE);

        settings[0] = '0;
        settings[1] = '1;
        settings[2] = '{7'd80, 7'd80, 7'd80, 7'd80, 7'd100, 7'd100, 7'd100, 7'd100};
        settings[3] = CFG_RESET;
        for (int p = 4; p < 7; p++)
            settings[p] = random_setting();

        for (int p = 0; p < 7; p++)
        begin
            drain();
            program_regs(settings[p]);
            quiet_run = ($urandom_range(0, 3) == 0);
            clock_ms  = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFA0 : $urandom;
            run_random(RANDOM_PER_PHASE);
        end

        drain();
        repeat (8) @(negedge clk);
        $display("covered %0d readings, %0d evaluations (%0d with a frontal obstacle),",
                 cmd_count[CMD_READING], cmd_count[CMD_EVALUATE], alarm_hits);
        $display("%0d pwm ticks and %0d unused commands under %0d register settings",
                 cmd_count[CMD_TICK], cmd_count[CMD_IDLE], settings_used + 1);
        if (fail_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
rtl/phd_pkg.sv
rtl/phd_if.sv
rtl/phd_sensor_window.sv
rtl/phd_drive_eval.sv
rtl/phd_pwm.sv
rtl/proximity_haptic_drive.sv
tb/sv/phd_drive_checker.sv
tb/sv/proximity_haptic_drive_test.sv
